### hdl/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg
// Types and constants shared by the ray to axis-segment proximity test core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsp_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Z     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEM_RADIUS = 2'd3;

  localparam logic [30:0] STEM_RADIUS_RST = 31'd3932;
  localparam logic [30:0] T_MAX           = 31'h7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] ray_origin_x;
    logic signed [31:0] ray_origin_y;
    logic signed [31:0] ray_origin_z;
    logic signed [31:0] ray_dir_x;
    logic signed [31:0] ray_dir_y;
    logic signed [31:0] ray_dir_z;
    logic signed [31:0] axis_end_x;
    logic signed [31:0] axis_end_y;
    logic signed [31:0] axis_end_z;
    logic        [30:0] axis_scale;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] ray_t;
  } out_item_t;

endpackage

`default_nettype wire

### hdl/rsp_mul.sv
// ----------------------------------------------------------------------------
// rsp_mul
// Two-stage signed multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsp_mul #(
  parameter int W = 64
) (
  input  logic                  clk_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  localparam int H  = (W + 1) / 2;
  localparam int SW = 4 * H;

  logic [W-1:0]     ua, ub;
  logic [H-1:0]     a_lo, a_hi, b_lo, b_hi;
  logic [2*H-1:0]   p00_q, p01_q, p10_q, p11_q;
  logic             neg_q;
  logic [SW-1:0]    sum;
  logic [2*W-1:0]   mag;
  logic [2*W-1:0]   p_d, p_q;

  assign ua   = a_i[W-1] ? W'(-a_i) : W'(a_i);
  assign ub   = b_i[W-1] ? W'(-b_i) : W'(b_i);
  assign a_lo = ua[H-1:0];
  assign a_hi = H'(ua >> H);
  assign b_lo = ub[H-1:0];
  assign b_hi = H'(ub >> H);

  always_ff @(posedge clk_i) begin
    p00_q <= a_lo * b_lo;
    p01_q <= a_lo * b_hi;
    p10_q <= a_hi * b_lo;
    p11_q <= a_hi * b_hi;
    neg_q <= a_i[W-1] ^ b_i[W-1];
  end

  always_comb begin
    sum = {p11_q, p00_q} + ((SW'(p01_q) + SW'(p10_q)) << H);
    mag = (2*W)'(sum);
    p_d = neg_q ? -mag : mag;
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = $signed(p_q);

endmodule

`default_nettype wire

### hdl/rsp_div.sv
// ----------------------------------------------------------------------------
// rsp_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsp_div #(
  parameter int DENW = 64,
  parameter int QB   = 16
) (
  input  logic            clk_i,
  input  logic [DENW-1:0] rem_i,
  input  logic [DENW-1:0] den_i,
  input  logic [QB-1:0]   tail_i,
  output logic [QB-1:0]   quo_o
);

  logic [DENW-1:0] rem_q  [QB];
  logic [DENW-1:0] den_q  [QB];
  logic [QB-1:0]   tail_q [QB];
  logic [QB-1:0]   quo_q  [QB];

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DENW-1:0] rem_in, den_in;
    logic [QB-1:0]   tail_in, quo_in;
    logic [DENW:0]   r2;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in  = rem_i;
      assign den_in  = den_i;
      assign tail_in = tail_i;
      assign quo_in  = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign tail_in = tail_q[k-1];
      assign quo_in  = quo_q[k-1];
    end

    assign r2 = {rem_in, tail_in[QB-1]};
    assign ge = r2 >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? DENW'(r2 - {1'b0, den_in}) : DENW'(r2);
      den_q[k]  <= den_in;
      tail_q[k] <= {tail_in[QB-2:0], 1'b0};
      quo_q[k]  <= {quo_in[QB-2:0], ge};
    end
  end

  assign quo_o = quo_q[QB-1];

endmodule

`default_nettype wire

### hdl/ray_segment_proximity_test_core.sv
// ----------------------------------------------------------------------------
// ray_segment_proximity_test_core
// Closest approach of a ray and the segment from the pivot to an end point,
// with a hit test against the scaled stem radius.
// throughput: one item per cycle; busy stays low
// the ray parameter comes from a 31-stage divider
// reset clears the valid pipeline and the configuration registers (stem radius to 3932)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ray_segment_proximity_test_core #(
  parameter int FRAC_BITS    = 16,
  parameter int PARALLEL_EPS = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  rsp_pkg::in_item_t                  in_item_i,
  output logic                               busy_o,
  output logic                               done_o,
  output rsp_pkg::out_item_t                 out_item_o,
  input  logic                               cfg_we_i,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rsp_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int SUMW = 68;
  localparam int DW   = SUMW - FRAC_BITS;
  localparam int MW   = 2 * DW;
  localparam int PW   = MW + 1;
  localparam int UW   = PW - 1;
  localparam int TQ   = 31;
  localparam int TSH  = TQ - FRAC_BITS;
  localparam int CW   = UW + TSH;
  localparam int SDLY = TQ - FRAC_BITS;
  localparam int ST_QUO   = 7 + TQ;
  localparam int SIDE_LEN = ST_QUO + 1;
  localparam int LAT      = ST_QUO + 5;

  localparam int DOT_DD = 0;
  localparam int DOT_DA = 1;
  localparam int DOT_AA = 2;
  localparam int DOT_DW = 3;
  localparam int DOT_AW = 4;

  localparam logic [1:0] S_ZERO = 2'd0;
  localparam logic [1:0] S_ONE  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  localparam logic signed [PW-1:0] EPS_V = PW'(PARALLEL_EPS) << FRAC_BITS;

  typedef struct packed {
    logic [2:0][31:0] d;
    logic [2:0][32:0] a;
    logic [2:0][32:0] w;
    logic [61:0]      rp;
  } side_t;

  typedef struct packed {
    logic       t_zero;
    logic       t_sat;
    logic [1:0] s_sel;
  } flag_t;

  // configuration registers
  logic signed [31:0] pivot_x_q, pivot_y_q, pivot_z_q;
  logic [30:0]        stem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_x_q <= '0;
      pivot_y_q <= '0;
      pivot_z_q <= '0;
      stem_q    <= rsp_pkg::STEM_RADIUS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rsp_pkg::REG_PIVOT_X:     pivot_x_q <= cfg_data_i;
        rsp_pkg::REG_PIVOT_Y:     pivot_y_q <= cfg_data_i;
        rsp_pkg::REG_PIVOT_Z:     pivot_z_q <= cfg_data_i;
        rsp_pkg::REG_STEM_RADIUS: stem_q    <= cfg_data_i[30:0];
        default:                  stem_q    <= stem_q;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // valid pipeline
  logic vld_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= start_i & ~busy_o;
      for (int k = 1; k < LAT; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // stage 1: segment and origin offsets
  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  logic signed [31:0] end_p [3];
  logic signed [31:0] piv [3];
  side_t              side_d;
  side_t              side_q [SIDE_LEN];

  always_comb begin
    org[0]   = in_item_i.ray_origin_x;
    org[1]   = in_item_i.ray_origin_y;
    org[2]   = in_item_i.ray_origin_z;
    dir[0]   = in_item_i.ray_dir_x;
    dir[1]   = in_item_i.ray_dir_y;
    dir[2]   = in_item_i.ray_dir_z;
    end_p[0] = in_item_i.axis_end_x;
    end_p[1] = in_item_i.axis_end_y;
    end_p[2] = in_item_i.axis_end_z;
    piv[0]   = pivot_x_q;
    piv[1]   = pivot_y_q;
    piv[2]   = pivot_z_q;
    for (int i = 0; i < 3; i++) begin
      side_d.d[i] = dir[i];
      side_d.a[i] = { end_p[i][31], end_p[i]} - {piv[i][31], piv[i]};
      side_d.w[i] = {org[i][31], org[i]} - {piv[i][31], piv[i]};
    end
    side_d.rp = {31'b0, stem_q} * {31'b0, in_item_i.axis_scale};
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int k = 1; k < SIDE_LEN; k++) side_q[k] <= side_q[k-1];
  end

  // stage 2: dot product terms
  logic signed [32:0] op_d [3];
  logic signed [32:0] op_a [3];
  logic signed [32:0] op_w [3];
  logic signed [65:0] prod_q [5][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      op_d[i] = $signed({side_q[0].d[i][31], side_q[0].d[i]});
      op_a[i] = $signed(side_q[0].a[i]);
      op_w[i] = $signed(side_q[0].w[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      prod_q[DOT_DD][i] <= op_d[i] * op_d[i];
      prod_q[DOT_DA][i] <= op_d[i] * op_a[i];
      prod_q[DOT_AA][i] <= op_a[i] * op_a[i];
      prod_q[DOT_DW][i] <= op_d[i] * op_w[i];
      prod_q[DOT_AW][i] <= op_a[i] * op_w[i];
    end
  end

  // stage 3: dot products
  logic signed [SUMW-1:0] dsum [5];
  logic signed [DW-1:0]   dot_q [5];

  always_comb begin
    for (int j = 0; j < 5; j++) begin
      dsum[j] = SUMW'(prod_q[j][0]) + SUMW'(prod_q[j][1]) + SUMW'(prod_q[j][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 5; j++) dot_q[j] <= DW'(dsum[j] >>> FRAC_BITS);
  end

  // stages 4-5: cross products
  logic signed [MW-1:0] m_den1, m_den2, m_tn1, m_tn2, m_sn1, m_sn2;

  rsp_mul #(.W(DW)) u_mul_den1 (
    .clk_i(clk_i), .a_i(dot_q[DOT_DD]), .b_i(dot_q[DOT_AA]), .p_o(m_den1));
  rsp_mul #(.W(DW)) u_mul_den2 (
    .clk_i(clk_i), .a_i(dot_q[DOT_DA]), .b_i(dot_q[DOT_DA]), .p_o(m_den2));
  rsp_mul #(.W(DW)) u_mul_tn1 (
    .clk_i(clk_i), .a_i(dot_q[DOT_DA]), .b_i(dot_q[DOT_AW]), .p_o(m_tn1));
  rsp_mul #(.W(DW)) u_mul_tn2 (
    .clk_i(clk_i), .a_i(dot_q[DOT_AA]), .b_i(dot_q[DOT_DW]), .p_o(m_tn2));
  rsp_mul #(.W(DW)) u_mul_sn1 (
    .clk_i(clk_i), .a_i(dot_q[DOT_DD]), .b_i(dot_q[DOT_AW]), .p_o(m_sn1));
  rsp_mul #(.W(DW)) u_mul_sn2 (
    .clk_i(clk_i), .a_i(dot_q[DOT_DA]), .b_i(dot_q[DOT_DW]), .p_o(m_sn2));

  logic signed [DW-1:0] aa_dly_q [2];
  logic signed [DW-1:0] aw_dly_q [2];

  always_ff @(posedge clk_i) begin
    aa_dly_q[0] <= dot_q[DOT_AA];
    aw_dly_q[0] <= dot_q[DOT_AW];
    aa_dly_q[1] <= aa_dly_q[0];
    aw_dly_q[1] <= aw_dly_q[0];
  end

  // stage 6: denominator and numerators
  logic signed [PW-1:0] den_q, tn_q, sn_q;
  logic signed [DW-1:0] aa6_q, aw6_q;

  always_ff @(posedge clk_i) begin
    den_q <= PW'(m_den1) - PW'(m_den2);
    tn_q  <= PW'(m_tn1) - PW'(m_tn2);
    sn_q  <= PW'(m_sn1) - PW'(m_sn2);
    aa6_q <= aa_dly_q[1];
    aw6_q <= aw_dly_q[1];
  end

  // stage 7: case selection and divider operands
  logic                 par, tn_pos;
  logic [UW-1:0]        tn_u, den_u;
  logic signed [PW-1:0] snum, sdv;
  flag_t                fl_d;
  logic [UW-1:0]        trem_q, tden_q, srem_q, sden_q;
  logic [TQ-1:0]        ttail_q;
  flag_t                fl_q [TQ+1];

  always_comb begin
    par    = den_q[PW-1] || (den_q == '0) || (den_q < EPS_V);
    tn_pos = !tn_q[PW-1] && (tn_q != '0);
    tn_u   = UW'(tn_q);
    den_u  = UW'(den_q);
    snum   = par ? PW'(aw6_q) : sn_q;
    sdv    = par ? PW'(aa6_q) : den_q;
    fl_d.t_zero = par || !tn_pos;
    fl_d.t_sat  = {{TSH{1'b0}}, tn_u} >= CW'({den_u, {TSH{1'b0}}});
    if ((par && aa6_q == '0) || snum[PW-1] || snum == '0) begin
      fl_d.s_sel = S_ZERO;
    end else if (!(snum < sdv)) begin
      fl_d.s_sel = S_ONE;
    end else begin
      fl_d.s_sel = S_DIV;
    end
  end

  always_ff @(posedge clk_i) begin
    trem_q  <= UW'(tn_u >> TSH);
    tden_q  <= den_u;
    ttail_q <= {tn_u[TSH-1:0], {FRAC_BITS{1'b0}}};
    srem_q  <= UW'(snum);
    sden_q  <= UW'(sdv);
    fl_q[0] <= fl_d;
    for (int k = 1; k <= TQ; k++) fl_q[k] <= fl_q[k-1];
  end

  // stages 8-38: dividers
  logic [TQ-1:0]        tquo;
  logic [FRAC_BITS-1:0] squo;
  logic [FRAC_BITS-1:0] sq_q [SDLY];

  rsp_div #(.DENW(UW), .QB(TQ)) u_div_t (
    .clk_i(clk_i), .rem_i(trem_q), .den_i(tden_q), .tail_i(ttail_q), .quo_o(tquo));

  rsp_div #(.DENW(UW), .QB(FRAC_BITS)) u_div_s (
    .clk_i(clk_i), .rem_i(srem_q), .den_i(sden_q), .tail_i('0), .quo_o(squo));

  always_ff @(posedge clk_i) begin
    sq_q[0] <= squo;
    for (int k = 1; k < SDLY; k++) sq_q[k] <= sq_q[k-1];
  end

  // stage 39: closest point terms
  logic [TQ-1:0]        t_fin;
  logic [FRAC_BITS:0]   s_fin;
  logic signed [63:0]   dt_q [3];
  logic signed [63:0]   as_q [3];
  logic [TQ-1:0]        t_q [4];

  always_comb begin
    if (fl_q[TQ].t_zero) begin
      t_fin = '0;
    end else if (fl_q[TQ].t_sat) begin
      t_fin = rsp_pkg::T_MAX;
    end else begin
      t_fin = tquo;
    end
    unique case (fl_q[TQ].s_sel)
      S_ZERO:  s_fin = '0;
      S_ONE:   s_fin = {1'b1, {FRAC_BITS{1'b0}}};
      default: s_fin = {1'b0, sq_q[SDLY-1]};
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dt_q[i] <= $signed(side_q[ST_QUO-1].d[i]) * $signed({1'b0, t_fin});
      as_q[i] <= $signed(side_q[ST_QUO-1].a[i]) * $signed({1'b0, s_fin});
    end
    t_q[0] <= t_fin;
    for (int k = 1; k < 4; k++) t_q[k] <= t_q[k-1];
  end

  // stage 40: closest difference per axis
  logic signed [63:0] c_q [3];
  logic signed [63:0] rin_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      c_q[i] <= 64'($signed(side_q[ST_QUO].w[i])) + (dt_q[i] >>> FRAC_BITS)
                - (as_q[i] >>> FRAC_BITS);
    end
    rin_q <= $signed(64'(side_q[ST_QUO].rp >> FRAC_BITS));
  end

  // stages 41-42: squares
  logic signed [127:0] sq_c [3];
  logic signed [127:0] sq_r;

  for (genvar i = 0; i < 3; i++) begin : g_sq
    rsp_mul #(.W(64)) u_mul_c (
      .clk_i(clk_i), .a_i(c_q[i]), .b_i(c_q[i]), .p_o(sq_c[i]));
  end

  rsp_mul #(.W(64)) u_mul_r (
    .clk_i(clk_i), .a_i(rin_q), .b_i(rin_q), .p_o(sq_r));

  // stage 43: threshold compare
  logic signed [129:0] dist2;
  logic                hit;
  rsp_pkg::out_item_t  out_q;

  always_comb begin
    dist2 = 130'(sq_c[0]) + 130'(sq_c[1]) + 130'(sq_c[2]);
    hit   = dist2 < 130'(sq_r);
  end

  always_ff @(posedge clk_i) begin
    out_q.hit   <= hit;
    out_q.ray_t <= hit ? t_q[3] : '0;
  end

  assign done_o     = vld_q[LAT-1];
  assign out_item_o = out_q;

endmodule

`default_nettype wire
